@@ design/assert_macros.svh @@
// Assertion macros shared by the digest unit RTL.
// No dependencies; the including module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ICD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Condition must never be true outside reset.
`define ICD_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ICD_ASSERT(label, prop)
`define ICD_ASSERT_NEVER(label, cond)
`endif
`endif

@@ design/icd_pkg.sv @@
// Shared types, constants and CRC-32C functions for the digest unit.
// No dependencies.
`default_nettype none

package icd_pkg;

    // Reflected Castagnoli polynomial and CRC start value
    localparam logic [31:0] CRC_POLY_REFL = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // Lane numbers
    localparam logic [1:0] LANE_ZERO = 2'd0;
    localparam logic [1:0] LANE_ONE  = 2'd1;
    localparam logic [1:0] LANE_TWO  = 2'd2;

    typedef enum logic [1:0] {
        OP_FEED  = 2'd0,   // fold data into a lane
        OP_FINAL = 2'd1,   // fold data, then finalize the message
        OP_SHORT = 2'd2    // message too short, report status only
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [1:0]  lane;
        logic [63:0] data;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // Reflected CRC-32C over 64 bits, LSB first
    function automatic logic [31:0] crc32c_64(input logic [31:0] crc_in,
                                              input logic [63:0] data);
        logic [31:0] c;
        logic        fb;
        c = crc_in;
        for (int i = 0; i < 64; i++) begin
            fb = c[0] ^ data[i];
            c  = {1'b0, c[31:1]} ^ (fb ? CRC_POLY_REFL : 32'h0);
        end
        return c;
    endfunction

    // Reflected CRC-32C over 96 bits, LSB first
    function automatic logic [31:0] crc32c_96(input logic [31:0] crc_in,
                                              input logic [95:0] data);
        logic [31:0] c;
        logic        fb;
        c = crc_in;
        for (int i = 0; i < 96; i++) begin
            fb = c[0] ^ data[i];
            c  = {1'b0, c[31:1]} ^ (fb ? CRC_POLY_REFL : 32'h0);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ design/icd_in_if.sv @@
// Chunk input channel: valid/ready handshake with chunk payload.
// No dependencies.
`default_nettype none

interface icd_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] chunk_data;
    logic        last_chunk;

    modport source (output valid, chunk_data, last_chunk, input ready);
    modport sink   (input valid, chunk_data, last_chunk, output ready);
endinterface

`default_nettype wire

@@ design/icd_out_if.sv @@
// Digest output channel: valid/ready handshake with digest payload.
// No dependencies.
`default_nettype none

interface icd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest;
    logic        status;

    modport source (output valid, digest, status, input ready);
    modport sink   (input valid, digest, status, output ready);
endinterface

`default_nettype wire

@@ design/icd_front.sv @@
// Front end: accepts chunks, holds the two newest back, assigns lanes
// and pushes lane operations into the queue. Uses icd_pkg, icd_in_if.
`default_nettype none

module icd_front
    import icd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    icd_in_if.sink     in,
    input  q_status_t  q_stat,
    output q_push_t    push
);

    logic [63:0] held0_reg, held0_next;
    logic [63:0] held1_reg, held1_next;
    logic [1:0]  held_cnt_reg, held_cnt_next;
    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  drain_reg, drain_next;

    logic [1:0]  phase_wrap;
    logic [1:0]  phase_sat;
    logic        accept;

    assign phase_wrap = (phase_reg == LANE_TWO) ? LANE_ZERO : phase_reg + 2'd1;
    assign phase_sat  = (phase_reg == LANE_TWO) ? LANE_TWO  : phase_reg + 2'd1;

    // No new beat while the tail of a message drains or the queue is full
    assign in.ready = (drain_reg == 2'd0) && !q_stat.full;
    assign accept   = in.valid && in.ready;

    always_comb
    begin
        held0_next    = held0_reg;
        held1_next    = held1_reg;
        held_cnt_next = held_cnt_reg;
        phase_next    = phase_reg;
        drain_next    = drain_reg;
        push.valid    = 1'b0;
        push.entry.op   = OP_FEED;
        push.entry.lane = phase_reg;
        push.entry.data = held0_reg;

        if (drain_reg != 2'd0)
        begin
            // Tail: remaining held chunks go to min(phase, 2)
            if (!q_stat.full)
            begin
                push.valid    = 1'b1;
                push.entry.op = (drain_reg == 2'd1) ? OP_FINAL : OP_FEED;
                held0_next    = held1_reg;
                phase_next    = phase_sat;
                drain_next    = drain_reg - 2'd1;
                if (drain_reg == 2'd1)
                begin
                    held_cnt_next = 2'd0;
                    phase_next    = LANE_ZERO;
                end
            end
        end
        else if (accept)
        begin
            if (!in.last_chunk)
            begin
                if (held_cnt_reg == 2'd2)
                begin
                    // Oldest held chunk is now known to be a full-group member
                    push.valid = 1'b1;
                    phase_next = phase_wrap;
                    held0_next = held1_reg;
                    held1_next = in.chunk_data;
                end
                else
                begin
                    if (held_cnt_reg == 2'd0)
                    begin
                        held0_next = in.chunk_data;
                    end
                    else
                    begin
                        held1_next = in.chunk_data;
                    end
                    held_cnt_next = held_cnt_reg + 2'd1;
                end
            end
            else if (held_cnt_reg != 2'd2)
            begin
                // Fewer than three chunks in the message
                push.valid    = 1'b1;
                push.entry.op = OP_SHORT;
                held_cnt_next = 2'd0;
                phase_next    = LANE_ZERO;
            end
            else
            begin
                // First of three pending chunks; two more follow
                push.valid = 1'b1;
                held0_next = held1_reg;
                held1_next = in.chunk_data;
                phase_next = phase_sat;
                drain_next = 2'd2;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cnt_reg <= 2'd0;
            phase_reg    <= LANE_ZERO;
            drain_reg    <= 2'd0;
        end
        else
        begin
            held_cnt_reg <= held_cnt_next;
            phase_reg    <= phase_next;
            drain_reg    <= drain_next;
        end
    end

    // Held chunk payload
    always_ff @(posedge clk)
    begin
        held0_reg <= held0_next;
        held1_reg <= held1_next;
    end

endmodule

`default_nettype wire

@@ design/icd_queue.sv @@
// Small FIFO of lane operations between front and back end.
// Uses icd_pkg.
`default_nettype none

module icd_queue
    import icd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  q_push_t    push,
    input  wire logic  pop,
    output q_entry_t   head,
    output q_status_t  stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    q_entry_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_FULL);
    assign head       = mem_reg[rd_ptr_reg];

    assign do_push = push.valid && !stat.full;
    assign do_pop  = pop && !stat.empty;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

`default_nettype wire

@@ design/icd_back.sv @@
// Back end: runs the three CRC-32C lanes, finalizes the message and
// holds the result beat. Uses icd_pkg, icd_out_if.
`default_nettype none

module icd_back
    import icd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  q_entry_t   head,
    input  q_status_t  q_stat,
    output logic       pop,
    icd_out_if.source  out
);

    logic [31:0] lane0_reg, lane0_next;
    logic [31:0] lane1_reg, lane1_next;
    logic [31:0] lane2_reg, lane2_next;
    logic        fin_reg, fin_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] digest_reg, digest_next;
    logic        status_reg, status_next;

    logic        out_free;
    logic [31:0] lane_cur;
    logic [31:0] lane_upd;
    logic [31:0] c0, c1, c2;
    logic [31:0] comb_crc;

    assign out_free  = !out_valid_reg || out.ready;
    assign out.valid = out_valid_reg;
    assign out.digest = digest_reg;
    assign out.status = status_reg;

    // Lanes stay untouched while a finished message waits for its digest
    assign pop = !q_stat.empty && !fin_reg && ((head.op != OP_SHORT) || out_free);

    // Selected lane and its update
    always_comb
    begin
        case (head.lane)
            LANE_ZERO: lane_cur = lane0_reg;
            LANE_ONE:  lane_cur = lane1_reg;
            default:   lane_cur = lane2_reg;
        endcase
    end
    assign lane_upd = crc32c_64(lane_cur, head.data);

    // Final lane values and the CRC over them
    assign c0       = ~lane0_reg;
    assign c1       = ~lane1_reg;
    assign c2       = ~lane2_reg;
    assign comb_crc = ~crc32c_96(CRC_INIT, {c2, c1, c0});

    always_comb
    begin
        lane0_next     = lane0_reg;
        lane1_next     = lane1_reg;
        lane2_next     = lane2_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg;
        digest_next    = digest_reg;
        status_next    = status_reg;

        if (out_valid_reg && out.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (fin_reg)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                digest_next    = {c0 ^ c1 ^ c2, comb_crc};
                status_next    = 1'b0;
                fin_next       = 1'b0;
                lane0_next     = CRC_INIT;
                lane1_next     = CRC_INIT;
                lane2_next     = CRC_INIT;
            end
        end
        else if (pop)
        begin
            case (head.op)
                OP_FEED, OP_FINAL:
                begin
                    case (head.lane)
                        LANE_ZERO: lane0_next = lane_upd;
                        LANE_ONE:  lane1_next = lane_upd;
                        default:   lane2_next = lane_upd;
                    endcase
                    fin_next = (head.op == OP_FINAL);
                end
                default:
                begin
                    out_valid_next = 1'b1;
                    digest_next    = 64'h0;
                    status_next    = 1'b1;
                    lane0_next     = CRC_INIT;
                    lane1_next     = CRC_INIT;
                    lane2_next     = CRC_INIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane0_reg     <= CRC_INIT;
            lane1_reg     <= CRC_INIT;
            lane2_reg     <= CRC_INIT;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lane0_reg     <= lane0_next;
            lane1_reg     <= lane1_next;
            lane2_reg     <= lane2_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        digest_reg <= digest_next;
        status_reg <= status_next;
    end

endmodule

`default_nettype wire

@@ design/interleaved_crc32c_digest_unit.sv @@
// Interleaved CRC-32C digest unit: top level.
// Uses icd_pkg, icd_in_if, icd_out_if, icd_front, icd_queue, icd_back.
//
// Usage:
//   in  : one beat per 8-byte chunk (byte 0 in bits 7:0); last_chunk marks
//         the final chunk of a message.
//   out : one beat per message, sent after its last chunk: digest holds
//         the XOR of the three lane CRCs (upper word) and the CRC-32C of
//         the three lane CRCs (lower word); status is 1 for a message of
//         fewer than three chunks, with a zero digest.
//   Throughput: one chunk per cycle inside a message while the queue is not
//   full, set by the single 64-bit lane update in the back end; the last chunk
//   of a message of three or more chunks blocks the input while the held
//   chunks drain into the queue.
//   Result path: the final lane operation passes the queue and the lane
//   update, then the digest is registered (a short message skips the lane update).
//   Reset: lanes return to all ones, the queue empties, no beat pending.
//   A stalled result is held in the output register; the queue keeps
//   taking chunks until it fills, then ready drops.
`default_nettype none
`include "assert_macros.svh"

module interleaved_crc32c_digest_unit
    import icd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    icd_in_if.sink     in,
    icd_out_if.source  out
);

    q_push_t   push;
    q_entry_t  head;
    q_status_t q_stat;
    logic      pop;

    icd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in     (in),
        .q_stat (q_stat),
        .push   (push)
    );

    icd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .stat  (q_stat)
    );

    icd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .out    (out)
    );

    // Checks
    `ICD_ASSERT(a_short_zero_digest, (out.valid && out.status) |-> (out.digest == 64'h0))
    `ICD_ASSERT(a_full_blocks_input, q_stat.full |-> !in.ready)
    `ICD_ASSERT_NEVER(a_queue_flags, q_stat.full && q_stat.empty)

endmodule

`default_nettype wire

@@ test/icd_digest_checker.sv @@
// Checker for the interleaved CRC-32C digest unit: watches both channels,
// predicts each digest beat and compares it. Uses icd_pkg, icd_in_if, icd_out_if.
module icd_digest_checker
    import icd_pkg::CRC_POLY_REFL, icd_pkg::CRC_INIT, icd_pkg::LANE_ZERO, icd_pkg::LANE_TWO;
(
    input  logic clk,
    input  logic rst_n,
    icd_in_if    in_ch,
    icd_out_if   out_ch,
    output int   fail_count,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_SHORT = 1'b1;
    localparam int   REPORT_MAX   = 10;

    typedef struct packed {
        logic [63:0] digest;
        logic        status;
    } digest_beat_t;

    // Predicted digest beats, oldest first
    digest_beat_t expected_digests[$];

    // Lane CRCs, held-back chunks and message position
    logic [31:0] lane_crc [3];
    logic [63:0] held [2];
    int          held_n;
    logic [1:0]  phase;
    int          seen;

    // Reflected CRC-32C over the first n bytes of buf, byte 0 in bits 7:0
    function automatic logic [31:0] crc32c_fold(input logic [31:0] acc,
                                                input logic [95:0] buf_bytes,
                                                input int n);
        logic [31:0] r;
        r = acc;
        for (int k = 0; k < n; k++) begin
            r = r ^ {24'h0, buf_bytes[8*k +: 8]};
            for (int b = 0; b < 8; b++)
                r = r[0] ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
        end
        return r;
    endfunction

    task automatic clear_message();
        lane_crc[0] = CRC_INIT;
        lane_crc[1] = CRC_INIT;
        lane_crc[2] = CRC_INIT;
        held[0] = '0;
        held[1] = '0;
        held_n = 0;
        phase = LANE_ZERO;
        seen = 0;
    endtask

    // Fold one accepted chunk into the lanes; queue a digest on the last one
    task automatic absorb_chunk(input logic [63:0] chunk, input logic last);
        logic [63:0]  pend [3];
        logic [31:0]  c0, c1, c2, comb;
        int           lane;
        digest_beat_t beat;
        if (seen < 3)
            seen++;
        if (!last) begin
            if (held_n >= 2) begin
                lane_crc[phase] = crc32c_fold(lane_crc[phase], {32'h0, held[0]}, 8);
                phase = (phase == LANE_TWO) ? LANE_ZERO : phase + 2'd1;
                held[0] = held[1];
                held[1] = chunk;
            end
            else begin
                held[held_n] = chunk;
                held_n++;
            end
        end
        else begin
            if (held_n < 2 || seen < 3) begin
                beat.digest = '0;
                beat.status = STATUS_SHORT;
            end
            else begin
                pend[0] = held[0];
                pend[1] = held[1];
                pend[2] = chunk;
                // trailing partial group lands in lane two
                for (int i = 0; i < 3; i++) begin
                    lane = int'(phase) + i;
                    if (lane > int'(LANE_TWO))
                        lane = LANE_TWO;
                    lane_crc[lane] = crc32c_fold(lane_crc[lane], {32'h0, pend[i]}, 8);
                end
                c0 = ~lane_crc[0];
                c1 = ~lane_crc[1];
                c2 = ~lane_crc[2];
                comb = ~crc32c_fold(CRC_INIT, {c2, c1, c0}, 12);
                beat.digest = {c0 ^ c1 ^ c2, comb};
                beat.status = STATUS_OK;
            end
            expected_digests.push_back(beat);
            clear_message();
        end
    endtask

    function automatic void note_failure(input string what, input digest_beat_t exp_beat,
                                         input logic [63:0] act_digest, input logic act_status);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%s: expected digest %h status %0b, got digest %h status %0b",
                     what, exp_beat.digest, exp_beat.status, act_digest, act_status);
    endfunction

    initial begin
        fail_count = 0;
        outstanding = 0;
        clear_message();
    end

    // Output beats are checked before the same edge's input beat is absorbed
    always @(posedge clk) begin
        digest_beat_t exp_beat;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_digests.size() == 0) begin
                    exp_beat = '0;
                    note_failure("unexpected digest beat", exp_beat,
                                 out_ch.digest, out_ch.status);
                end
                else begin
                    exp_beat = expected_digests.pop_front();
                    if (out_ch.digest !== exp_beat.digest || out_ch.status !== exp_beat.status)
                        note_failure("digest beat mismatch", exp_beat,
                                     out_ch.digest, out_ch.status);
                end
            end
            if (in_ch.valid && in_ch.ready)
                absorb_chunk(in_ch.chunk_data, in_ch.last_chunk);
            outstanding = expected_digests.size();
        end
    end

endmodule

@@ test/tb_interleaved_crc32c_digest_unit.sv @@
// Testbench top for the interleaved CRC-32C digest unit: drives chunk messages,
// stalls the result side and gives the verdict. Uses icd_digest_checker and the RTL.
module tb_interleaved_crc32c_digest_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHUNK_TARGET = 1750;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 20;
    localparam int IDLE_PCT     = 32;

    logic clk;
    logic rst_n;
    logic calm;
    logic hold_go;
    logic hold_done;
    int   chunks_sent;
    int   idle_cycles;
    int   fail_count;
    int   outstanding;

    icd_in_if  in_ch();
    icd_out_if out_ch();

    interleaved_crc32c_digest_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch),
        .out   (out_ch)
    );

    icd_digest_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Mostly random payloads, with the all-zero and all-one words now and then
    function automatic logic [63:0] pick_chunk();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // Offer one beat from a falling edge; returns at the falling edge after acceptance
    task automatic send_chunk(input logic [63:0] data, input logic last);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.chunk_data <= data;
        in_ch.last_chunk <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        chunks_sent++;
        @(negedge clk);
    endtask

    task automatic send_message(input int len);
        for (int k = 0; k < len; k++)
            send_chunk(pick_chunk(), k == len - 1);
    endtask

    // Result side: random stalls, one long hold-off, a calm window
    initial begin
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_go && !hold_done) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            else begin
                out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog on cycles with no beat on either channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
            else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int r;
        int len;
        in_ch.valid      = 1'b0;
        in_ch.chunk_data = '0;
        in_ch.last_chunk = 1'b0;
        out_ch.ready     = 1'b0;
        rst_n       = 1'b0;
        calm        = 1'b0;
        hold_go     = 1'b0;
        hold_done   = 1'b0;
        chunks_sent = 0;
        idle_cycles = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Short messages: one chunk, then two
        send_chunk('1, 1'b1);
        send_chunk('0, 1'b0);
        send_chunk('1, 1'b1);
        // Three chunks: finish starts at lane zero
        send_chunk('0, 1'b0);
        send_chunk('1, 1'b0);
        send_chunk(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        // Four chunks: finish starts at lane one
        send_chunk(64'h5555_5555_5555_5555, 1'b0);
        send_chunk(64'h0123_4567_89AB_CDEF, 1'b0);
        send_chunk(64'h8000_0000_0000_0001, 1'b0);
        send_chunk('1, 1'b1);
        // Five chunks: finish starts at lane two, three chunks fold into lane two
        send_message(5);
        // Seven chunks: the lane order wraps before the finish
        send_message(7);

        // Random messages, mostly well-formed lengths
        while (chunks_sent < CHUNK_TARGET) begin
            calm = (chunks_sent >= 900 && chunks_sent < 1150);
            if (chunks_sent >= 500)
                hold_go = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 8)
                len = $urandom_range(1, 2);
            else if (r < 80)
                len = $urandom_range(3, 12);
            else
                len = $urandom_range(13, 40);
            send_message(len);
        end
        calm = 1'b0;
        in_ch.valid <= 1'b0;

        // Drain, then wait for any stray beats
        while (outstanding != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
